// ===== rtl/core/pwq_pkg.sv =====
// Shared types and constants for the priority wait queue.
package pwq_pkg;

  localparam int unsigned PRIO_W     = 64;
  localparam int unsigned TIE_W      = 32;
  localparam int unsigned ID_FIELD_W = 16;
  localparam int unsigned POS_W      = 6;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [ID_FIELD_W-1:0] waiter_id;
    logic [PRIO_W-1:0]     priority_time;
    logic [TIE_W-1:0]      tie_value;
  } pwq_in_t;

  typedef struct packed {
    logic [POS_W-1:0]      position;
    logic [ID_FIELD_W-1:0] head_id;
    logic                  head_valid;
    logic                  overflow;
  } pwq_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_RM_POP,
    ST_DONE
  } pwq_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // latch request, clear result, idx = count
    logic rd_prev;  // read entry idx-1
    logic shift;    // move read entry to idx, step idx down, read idx-2
    logic put;      // write new entry at idx, count up, report position
    logic rd_head;  // read head entry
    logic pop;      // report head, advance head, count down
    logic set_ovf;  // report refused insert
  } pwq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic remove;
    logic full;
    logic empty;
    logic beats;
    logic idx_le1;
  } pwq_stat_t;

endpackage

// ===== rtl/core/pwq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pwq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pwq_ctrl.sv =====
// Controller state machine for the priority wait queue.
module pwq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  pwq_pkg::pwq_stat_t stat,
  output pwq_pkg::pwq_cmd_t  cmd,
  output logic              busy,
  output logic              out_valid
);

  pwq_pkg::pwq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pwq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      pwq_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = pwq_pkg::ST_DISPATCH;
        end
      end
      pwq_pkg::ST_DISPATCH: begin
        priority if (stat.remove && stat.empty) begin
          state_nxt = pwq_pkg::ST_DONE;
        end else if (stat.remove) begin
          cmd.rd_head = 1'b1;
          state_nxt   = pwq_pkg::ST_RM_POP;
        end else if (stat.full) begin
          cmd.set_ovf = 1'b1;
          state_nxt   = pwq_pkg::ST_DONE;
        end else if (stat.empty) begin
          cmd.put   = 1'b1;
          state_nxt = pwq_pkg::ST_DONE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = pwq_pkg::ST_INS_CMP;
        end
      end
      pwq_pkg::ST_INS_CMP: begin
        // walk from the tail, moving beaten entries up one slot
        if (stat.beats) begin
          cmd.shift = 1'b1;
          if (stat.idx_le1) begin
            state_nxt = pwq_pkg::ST_INS_PUT;
          end
        end else begin
          cmd.put   = 1'b1;
          state_nxt = pwq_pkg::ST_DONE;
        end
      end
      pwq_pkg::ST_INS_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = pwq_pkg::ST_DONE;
      end
      pwq_pkg::ST_RM_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = pwq_pkg::ST_DONE;
      end
      pwq_pkg::ST_DONE: begin
        state_nxt = pwq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pwq_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != pwq_pkg::ST_IDLE);
  assign out_valid = (state_r == pwq_pkg::ST_DONE);

endmodule

// ===== rtl/core/pwq_datapath.sv =====
// Datapath: circular entry store, head and fill counters, compare and result register.
module pwq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pwq_pkg::pwq_cmd_t  cmd,
  output pwq_pkg::pwq_stat_t stat,
  input  pwq_pkg::pwq_in_t   in_request,
  output pwq_pkg::pwq_out_t  out_result
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = CW + 1;
  localparam int unsigned OW = (ID_WIDTH < pwq_pkg::ID_FIELD_W) ? ID_WIDTH
                                                                : pwq_pkg::ID_FIELD_W;
  localparam int unsigned EW = pwq_pkg::PRIO_W + pwq_pkg::TIE_W + OW;

  logic [CW-1:0]     count_r;
  logic [AW-1:0]     head_r;
  logic [CW-1:0]     idx_r;
  pwq_pkg::pwq_in_t  req_r;
  pwq_pkg::pwq_out_t res_r;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [EW-1:0]             ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [EW-1:0]             ram_rdata;
  logic [EW-1:0]             new_entry;
  logic [pwq_pkg::PRIO_W-1:0] rd_prio;
  logic [pwq_pkg::TIE_W-1:0]  rd_tie;
  logic [OW-1:0]             rd_owner;
  logic [CW-1:0]             idx_m1;
  logic [CW-1:0]             idx_m2;

  // Logical slot k sits at head + k, wrapped at the depth.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] k);
    logic [PW-1:0] s;
    s = PW'(head) + PW'(k);
    if (s >= PW'(QUEUE_DEPTH)) begin
      s = s - PW'(QUEUE_DEPTH);
    end
    return AW'(s);
  endfunction

  assign idx_m1    = idx_r - CW'(1);
  assign idx_m2    = idx_r - CW'(2);
  assign new_entry = {req_r.priority_time, req_r.tie_value, req_r.waiter_id[OW-1:0]};
  assign rd_prio   = ram_rdata[EW-1 -: pwq_pkg::PRIO_W];
  assign rd_tie    = ram_rdata[OW + pwq_pkg::TIE_W - 1 -: pwq_pkg::TIE_W];
  assign rd_owner  = ram_rdata[OW-1:0];

  assign ram_we    = cmd.put | cmd.shift;
  assign ram_waddr = phys(head_r, idx_r);
  assign ram_wdata = cmd.put ? new_entry : ram_rdata;
  assign ram_re    = cmd.rd_prev | cmd.rd_head | (cmd.shift & ~stat.idx_le1);

  always_comb begin
    priority if (cmd.rd_head) begin
      ram_raddr = head_r;
    end else if (cmd.shift) begin
      ram_raddr = phys(head_r, idx_m2);
    end else begin
      ram_raddr = phys(head_r, idx_m1);
    end
  end

  pwq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.remove  = (req_r.action == pwq_pkg::ACT_REMOVE);
    stat.full    = (count_r == CW'(QUEUE_DEPTH));
    stat.empty   = (count_r == '0);
    stat.beats   = (req_r.priority_time < rd_prio) ||
                   ((req_r.priority_time == rd_prio) && (req_r.tie_value < rd_tie));
    stat.idx_le1 = (idx_r <= CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
    end else begin
      if (cmd.put) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.pop) begin
        count_r <= count_r - CW'(1);
        head_r  <= (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_request;
      idx_r <= count_r;
      res_r <= '0;
    end else begin
      if (cmd.shift) begin
        idx_r <= idx_m1;
      end
      if (cmd.put) begin
        res_r.position <= pwq_pkg::POS_W'(idx_r);
      end
      if (cmd.pop) begin
        res_r.head_id    <= pwq_pkg::ID_FIELD_W'(rd_owner);
        res_r.head_valid <= 1'b1;
      end
      if (cmd.set_ovf) begin
        res_r.overflow <= 1'b1;
      end
    end
  end

  assign out_result = res_r;

endmodule

// ===== rtl/core/priority_wait_queue_top.sv =====
// Top level of the priority wait queue: controller, datapath and checks.
//
// A request is taken when start is high and busy is low; busy stays high until
// its result has been shown. Each request gives exactly one result, held on
// out_result for a single cycle while out_valid is high, and the receiver must
// take it then. A remove that finds a waiter goes from the dispatch state to the
// pop state and then to the result; a remove from an empty queue, a refused
// insert or an insert into an empty queue goes from dispatch straight to the
// result. An insert into a queue holding at least one entry walks from the tail
// toward the head one entry per cycle through the single read port of the
// entry memory, moving each entry it beats up by one slot. A new request can
// be taken in the cycle right after the result cycle. The store is circular,
// so a remove never moves entries. No clearing pass follows reset.
module priority_wait_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pwq_pkg::pwq_in_t  in_request,
  output logic              out_valid,
  output pwq_pkg::pwq_out_t out_result
);

  pwq_pkg::pwq_cmd_t  cmd;
  pwq_pkg::pwq_stat_t stat;

  pwq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  pwq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_request (in_request),
    .out_result (out_result)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("result strobe not followed by idle");

  a_no_put_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.put && stat.full))
    else $error("write into a full queue");

  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_result.head_valid && out_result.overflow))
    else $error("remove and refused insert flagged together");
`endif

endmodule
